>>> hdl/cv3_pkg.sv
// Package for the 3x3 grayscale convolution block: sizes, register indexes,
// item codes and the window edge-mask type.
// Depends on nothing; used by conv3x3_gray_zero_pad_top.
package cv3_pkg;

    // Longest image row the line stores can hold.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);

    // Field and register widths.
    localparam int PIX_W = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int COEF_W = 24;
    localparam int COEF_BYTE_W = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int ROW_W = HEIGHT_REG_W;

    // Product of an unsigned pixel and a signed coefficient, and the sum of nine.
    localparam int PROD_W = PIX_W + COEF_BYTE_W + 1;
    localparam int SUM_W = PROD_W + 4;
    localparam int PIX_MAX = (1 << PIX_W) - 1;

    // Register reset values.
    localparam int WIDTH_RESET = 512;
    localparam int HEIGHT_RESET = 512;
    localparam logic [COEF_W-1:0] COEF_TOP_RESET = 24'h000000;
    localparam logic [COEF_W-1:0] COEF_MID_RESET = 24'h000100;
    localparam logic [COEF_W-1:0] COEF_BOTTOM_RESET = 24'h000000;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_ROW_TOP = 3'd2,
        CFG_COEF_ROW_MID = 3'd3,
        CFG_COEF_ROW_BOTTOM = 3'd4
    } cfg_reg_t;

    // Item kinds carried in tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Window rows and columns that fall outside the image.
    typedef struct packed {
        logic skip_top;
        logic skip_bottom;
        logic skip_left;
        logic skip_right;
    } edge_mask_t;

    // Index of the last column for a programmed width (0 acts as 1, clamp to MAX_WIDTH).
    function automatic logic [COL_W-1:0] width_last(input logic [WIDTH_REG_W-1:0] w);
        logic [COL_W-1:0] result;
        if (w == '0) begin
            result = '0;
        end else if (int'(w) > MAX_WIDTH) begin
            result = COL_W'(MAX_WIDTH - 1);
        end else begin
            result = COL_W'(w - WIDTH_REG_W'(1));
        end
        return result;
    endfunction

    // Index of the last row for a programmed height (0 acts as 1).
    function automatic logic [ROW_W-1:0] height_last(input logic [HEIGHT_REG_W-1:0] h);
        logic [ROW_W-1:0] result;
        if (h == '0) begin
            result = '0;
        end else begin
            result = ROW_W'(h - HEIGHT_REG_W'(1));
        end
        return result;
    endfunction

endpackage

>>> hdl/cv3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued. No dependencies.
module cv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/conv3x3_gray_zero_pad_top.sv
// Top level of the 3x3 grayscale convolution with zero padding: line stores,
// sliding window, products and saturating sum. Depends on cv3_pkg and cv3_ram.
//
//   channel  direction  ports                               word contents
//   s_       in         s_tvalid s_tready s_tdata s_tuser   tdata: pixel_in; tuser: opcode
//   m_       out        m_tvalid m_tready m_tdata m_tlast   tdata: pixel_out; tlast: last_of_frame
//   cfg_     in         cfg_wr_en cfg_addr cfg_wr_data      register index and value
//
// One word is accepted per clock while s_tready is high; a word with a result shows it on
// m_ after the read stage, the product stage and the result register (line store read at
// acceptance, products, then saturated sum). A line store read can meet the write back of
// the word before it in the same clock; a one-entry bypass covers a one-pixel-wide image.
// Reset is synchronous, active low, and loads the default geometry and kernel. While a result
// waits on m_tready, one more result word can wait in each of the product and read stages.
module conv3x3_gray_zero_pad_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input words.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cv3_pkg::PIX_W-1:0]       s_tdata,    // [7:0] pixel_in
    input  logic                            s_tuser,    // [0] opcode
    // Result words.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cv3_pkg::PIX_W-1:0]       m_tdata,    // [7:0] pixel_out
    output logic                            m_tlast,
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [cv3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cv3_pkg::COEF_W-1:0]      cfg_wr_data
);

    localparam int COL_W = cv3_pkg::COL_W;
    localparam int ROW_W = cv3_pkg::ROW_W;
    localparam int PIX_W = cv3_pkg::PIX_W;
    localparam int PROD_W = cv3_pkg::PROD_W;
    localparam int SUM_W = cv3_pkg::SUM_W;
    localparam int CB_W = cv3_pkg::COEF_BYTE_W;

    // Configuration.
    logic [COL_W-1:0]            width_last_reg;
    logic [ROW_W-1:0]            height_last_reg;
    logic [cv3_pkg::COEF_W-1:0]  coef_top_reg;
    logic [cv3_pkg::COEF_W-1:0]  coef_mid_reg;
    logic [cv3_pkg::COEF_W-1:0]  coef_bottom_reg;

    // Frame position.
    logic [COL_W-1:0]  in_col_reg;
    logic [1:0]        rows_seen_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;

    // Read stage.
    logic                     s1_valid_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [PIX_W-1:0]         s1_pix_reg;
    logic                     s1_emit_reg;
    logic                     s1_last_reg;
    cv3_pkg::edge_mask_t      s1_mask_reg;
    logic                     s1_byp_reg;
    logic [PIX_W-1:0]         byp_top_reg;
    logic [PIX_W-1:0]         byp_mid_reg;

    // Window and product stage.
    logic [PIX_W-1:0]         win_reg [3][3];
    logic [PIX_W-1:0]         win_next [3][3];
    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];

    // Result register.
    logic                     out_valid_reg;
    logic [PIX_W-1:0]         out_pix_reg;
    logic                     out_last_reg;

    // Handshake and datapath wires.
    logic                     out_free;
    logic                     s2_space;
    logic                     s1_go;
    logic                     accept;
    logic [PIX_W-1:0]         older_rdata;
    logic [PIX_W-1:0]         newer_rdata;
    logic [PIX_W-1:0]         top_pix;
    logic [PIX_W-1:0]         mid_pix;
    logic [PIX_W-1:0]         incoming;
    logic                     emit;
    logic                     last;
    cv3_pkg::edge_mask_t      mask;
    logic signed [SUM_W-1:0]  acc;
    logic [PIX_W-1:0]         sat_pix;

    // Stage flow: each stage moves when the one after it has room.
    assign out_free = !out_valid_reg || m_tready;
    assign s2_space = !s2_valid_reg || out_free;
    assign s1_go = s1_valid_reg && (!s1_emit_reg || s2_space);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept = s_tvalid && s_tready;

    // Decode of the accepted word against the frame position.
    always_comb begin
        incoming = (s_tuser == cv3_pkg::OP_DRAIN) ? '0 : s_tdata;
        emit = (rows_seen_reg == 2'd2) || (rows_seen_reg == 2'd1 && in_col_reg != '0);
        last = (out_row_reg == height_last_reg) && (out_col_reg == width_last_reg);
        mask.skip_top = (out_row_reg == '0);
        mask.skip_bottom = (out_row_reg == height_last_reg);
        mask.skip_left = (out_col_reg == '0);
        mask.skip_right = (out_col_reg == width_last_reg);
    end

    // Configuration registers and frame position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg <= cv3_pkg::width_last(cv3_pkg::WIDTH_REG_W'(cv3_pkg::WIDTH_RESET));
            height_last_reg <= cv3_pkg::height_last(
                cv3_pkg::HEIGHT_REG_W'(cv3_pkg::HEIGHT_RESET));
            coef_top_reg <= cv3_pkg::COEF_TOP_RESET;
            coef_mid_reg <= cv3_pkg::COEF_MID_RESET;
            coef_bottom_reg <= cv3_pkg::COEF_BOTTOM_RESET;
            in_col_reg <= '0;
            rows_seen_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                cv3_pkg::CFG_IMAGE_WIDTH: begin
                    width_last_reg <= cv3_pkg::width_last(
                        cfg_wr_data[cv3_pkg::WIDTH_REG_W-1:0]);
                    in_col_reg <= '0;
                    rows_seen_reg <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                cv3_pkg::CFG_IMAGE_HEIGHT: begin
                    height_last_reg <= cv3_pkg::height_last(
                        cfg_wr_data[cv3_pkg::HEIGHT_REG_W-1:0]);
                    in_col_reg <= '0;
                    rows_seen_reg <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                cv3_pkg::CFG_COEF_ROW_TOP: begin
                    coef_top_reg <= cfg_wr_data;
                end
                cv3_pkg::CFG_COEF_ROW_MID: begin
                    coef_mid_reg <= cfg_wr_data;
                end
                cv3_pkg::CFG_COEF_ROW_BOTTOM: begin
                    coef_bottom_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (emit && last) begin
                // Final output of the frame: the next word starts a new frame.
                in_col_reg <= '0;
                rows_seen_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (in_col_reg == width_last_reg) begin
                    in_col_reg <= '0;
                    if (rows_seen_reg != 2'd2) begin
                        rows_seen_reg <= rows_seen_reg + 2'd1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
                if (emit) begin
                    if (out_col_reg == width_last_reg) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // Line stores: read at acceptance, written back when the word leaves the read stage.
    cv3_ram #(
        .WIDTH(PIX_W),
        .DEPTH(cv3_pkg::MAX_WIDTH)
    ) u_line_older (
        .aclk    (aclk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (mid_pix),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (older_rdata)
    );

    cv3_ram #(
        .WIDTH(PIX_W),
        .DEPTH(cv3_pkg::MAX_WIDTH)
    ) u_line_newer (
        .aclk    (aclk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (newer_rdata)
    );

    // A read that meets the write of the same column takes the written values.
    assign top_pix = s1_byp_reg ? byp_top_reg : older_rdata;
    assign mid_pix = s1_byp_reg ? byp_mid_reg : newer_rdata;

    // Read stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg <= in_col_reg;
            s1_pix_reg <= incoming;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_mask_reg <= mask;
            s1_byp_reg <= s1_go && (s1_col_reg == in_col_reg);
            byp_top_reg <= mid_pix;
            byp_mid_reg <= s1_pix_reg;
        end
    end

    // Window shift and masked products of the flipped kernel.
    always_comb begin
        logic [CB_W-1:0]          cbyte;
        logic [cv3_pkg::COEF_W-1:0] cword;
        logic signed [PROD_W-1:0] a_op;
        logic signed [PROD_W-1:0] b_op;
        logic                     skip;
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_pix;
        win_next[1][2] = mid_pix;
        win_next[2][2] = s1_pix_reg;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // Window row r meets kernel row 2-r, column c meets kernel column 2-c.
                cword = (r == 0) ? coef_bottom_reg : ((r == 1) ? coef_mid_reg : coef_top_reg);
                cbyte = cword[(2 - c) * CB_W +: CB_W];
                a_op = $signed({{(PROD_W - PIX_W){1'b0}}, win_next[r][c]});
                b_op = $signed({{(PROD_W - CB_W){cbyte[CB_W-1]}}, cbyte});
                skip = (r == 0 && s1_mask_reg.skip_top) || (r == 2 && s1_mask_reg.skip_bottom)
                    || (c == 0 && s1_mask_reg.skip_left) || (c == 2 && s1_mask_reg.skip_right);
                prod_next[r * 3 + c] = skip ? '0 : a_op * b_op;
            end
        end
    end

    // Window state moves with every word; products only for words with a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (s1_go) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_space) begin
            s2_valid_reg <= s1_go && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_space && s1_go && s1_emit_reg) begin
            prod_reg <= prod_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Sum of the nine products, saturated to the pixel range.
    always_comb begin
        acc = SUM_W'(prod_reg[0]);
        for (int i = 1; i < 9; i++) begin
            acc = acc + SUM_W'(prod_reg[i]);
        end
        if (acc < 0) begin
            sat_pix = '0;
        end else if (acc > SUM_W'(cv3_pkg::PIX_MAX)) begin
            sat_pix = PIX_W'(cv3_pkg::PIX_MAX);
        end else begin
            sat_pix = acc[PIX_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s2_valid_reg) begin
            out_pix_reg <= sat_pix;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_pix_reg;
    assign m_tlast = out_last_reg;

endmodule
